[rtl/qrs_pkg.sv]
// shared widths, codes and types of the quadratic root solver
package qrs_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_WIDTH  = 35;

    // discriminant magnitude: b*b + 4*|a*c|
    localparam int PROD_W   = 2 * COEF_WIDTH;
    localparam int DISC_W   = PROD_W + 3;
    localparam int SQ_W     = (DISC_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W    = 2 * SQ_W;
    localparam int SQ_REM_W = SQ_W + 2;

    // dividend and divisor magnitudes
    localparam int SCL_W = COEF_WIDTH + FRAC_BITS;
    localparam int NUM_W = ((SCL_W > SQ_W) ? SCL_W : SQ_W) + 1;
    localparam int DEN_W = COEF_WIDTH + 1;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_LINEAR   = 3'd1,
        KIND_TWO_REAL = 3'd2,
        KIND_ONE_REAL = 3'd3,
        KIND_COMPLEX  = 3'd4
    } t_kind;

    typedef logic signed [COEF_WIDTH-1:0] t_coef;
    typedef logic signed [OUT_WIDTH-1:0]  t_root;

    typedef struct packed {
        t_kind kind;
        t_coef a;
        t_coef b;
        t_coef c;
    } t_sq_ctx;

    typedef struct packed {
        t_kind kind;
        logic  neg1;
        logic  neg2;
    } t_dv_ctx;

    function automatic logic [COEF_WIDTH-1:0] coef_mag(t_coef v);
        return v[COEF_WIDTH-1] ? COEF_WIDTH'(-v) : COEF_WIDTH'(v);
    endfunction

endpackage

[rtl/qrs_ifs.sv]
// valid/ready channels for coefficients and roots
interface qrs_in_if import qrs_pkg::*;;
    logic  valid;
    logic  ready;
    t_coef coef_a;
    t_coef coef_b;
    t_coef coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_out_if import qrs_pkg::*;;
    logic       valid;
    logic       ready;
    logic [2:0] root_kind;
    t_root      first_root;
    t_root      second_root;

    modport source (output valid, output root_kind, output first_root, output second_root,
                    input ready);
    modport sink   (input valid, input root_kind, input first_root, input second_root,
                    output ready);
endinterface

[rtl/qrs_sqrt_cell.sv]
// one digit step of the pipelined integer square root
module qrs_sqrt_cell import qrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [RAD_W-1:0]    i_rad,
    input  logic [SQ_REM_W-1:0] i_rem,
    input  logic [SQ_W-1:0]     i_root,
    input  t_sq_ctx             i_ctx,
    output logic                o_valid,
    output logic [RAD_W-1:0]    o_rad,
    output logic [SQ_REM_W-1:0] o_rem,
    output logic [SQ_W-1:0]     o_root,
    output t_sq_ctx             o_ctx
);
    logic [SQ_REM_W-1:0] w_sh;
    logic [SQ_REM_W-1:0] w_cand;
    logic                w_ge;

    always_comb begin
        w_sh   = {i_rem[SQ_REM_W-3:0], i_rad[RAD_W-1 -: 2]};
        w_cand = {i_root, 2'b01};
        w_ge   = (w_sh >= w_cand);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            o_rem  <= w_ge ? (w_sh - w_cand) : w_sh;
            o_root <= {i_root[SQ_W-2:0], w_ge};
            o_ctx  <= i_ctx;
        end
    end
endmodule

[rtl/qrs_div_cell.sv]
// one quotient bit of two restoring divisions that share a divisor
module qrs_div_cell import qrs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DEN_W-1:0] i_den,
    input  logic [DEN_W-1:0] i_rem1,
    input  logic [DEN_W-1:0] i_rem2,
    input  logic [NUM_W-1:0] i_num1,
    input  logic [NUM_W-1:0] i_num2,
    input  t_dv_ctx          i_ctx,
    output logic             o_valid,
    output logic [DEN_W-1:0] o_den,
    output logic [DEN_W-1:0] o_rem1,
    output logic [DEN_W-1:0] o_rem2,
    output logic [NUM_W-1:0] o_num1,
    output logic [NUM_W-1:0] o_num2,
    output t_dv_ctx          o_ctx
);
    logic [DEN_W:0] w_t1, w_t2, w_d;
    logic           w_ge1, w_ge2;
    logic [DEN_W:0] w_r1, w_r2;

    always_comb begin
        w_d   = {1'b0, i_den};
        w_t1  = {i_rem1, i_num1[NUM_W-1]};
        w_t2  = {i_rem2, i_num2[NUM_W-1]};
        w_ge1 = (w_t1 >= w_d);
        w_ge2 = (w_t2 >= w_d);
        w_r1  = w_ge1 ? (w_t1 - w_d) : w_t1;
        w_r2  = w_ge2 ? (w_t2 - w_d) : w_t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_den  <= i_den;
            o_rem1 <= w_r1[DEN_W-1:0];
            o_rem2 <= w_r2[DEN_W-1:0];
            // quotient bits fill the dividend from the bottom
            o_num1 <= {i_num1[NUM_W-2:0], w_ge1};
            o_num2 <= {i_num2[NUM_W-2:0], w_ge2};
            o_ctx  <= i_ctx;
        end
    end
endmodule

[rtl/quadratic_root_solver_core.sv]
// quadratic root solver: classify a*x^2+b*x+c=0 and return roots in fixed point
//
// i_coef carries one coefficient set (a, b, c) per transaction; o_root returns
// the kind and two roots with FRAC_BITS fraction bits, truncated toward zero.
// The pipeline has two stages for the products and the discriminant, a row
// of SQ_W square root cells, a stage that forms the dividends, a row of NUM_W
// divider cells, and the output register with sign and saturation.
// Throughput is one transaction per cycle unless the receiver stalls: every
// cell hands its data to the next each cycle, so a new set enters while
// earlier ones are still in flight.
// When the receiver stalls with a result pending, the whole row holds and
// i_coef.ready drops in the same cycle; it rises again as soon as the output
// register is taken. Reset clears all valid bits but no data registers;
// nothing else needs clearing and the block accepts work right after reset.
module quadratic_root_solver_core import qrs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qrs_in_if.sink    i_coef,
    qrs_out_if.source o_root
);
    localparam int SAT_W = ((NUM_W + 1 > OUT_WIDTH) ? NUM_W + 1 : OUT_WIDTH) + 1;
    localparam logic signed [SAT_W-1:0] SAT_MAX =
        {{(SAT_W - OUT_WIDTH + 1){1'b0}}, {(OUT_WIDTH - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_MIN = ~SAT_MAX;

    function automatic t_root saturate(logic signed [NUM_W:0] v);
        logic signed [SAT_W-1:0] w;
        w = SAT_W'(v);
        if (w > SAT_MAX) w = SAT_MAX;
        if (w < SAT_MIN) w = SAT_MIN;
        return w[OUT_WIDTH-1:0];
    endfunction

    function automatic logic signed [NUM_W:0] scale_neg(t_coef v);
        logic signed [NUM_W:0] x;
        x = (NUM_W + 1)'(v);
        return -(x <<< FRAC_BITS);
    endfunction

    logic w_en;
    assign w_en         = !o_root.valid || o_root.ready;
    assign i_coef.ready = w_en;

    // products
    logic                r1_valid;
    logic [PROD_W-1:0]   r1_b2, r1_ac;
    t_sq_ctx             r1_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_coef.valid;
        end
        if (w_en) begin
            r1_b2      <= coef_mag(i_coef.coef_b) * coef_mag(i_coef.coef_b);
            r1_ac      <= coef_mag(i_coef.coef_a) * coef_mag(i_coef.coef_c);
            r1_ctx.a   <= i_coef.coef_a;
            r1_ctx.b   <= i_coef.coef_b;
            r1_ctx.c   <= i_coef.coef_c;
            r1_ctx.kind <= KIND_NONE;
        end
    end

    // discriminant and classification
    logic [DISC_W-1:0] w_b2, w_p4, w_d;
    logic              w_dneg;
    t_kind             w_kind;
    logic              r2_valid;
    logic [RAD_W-1:0]  r2_rad;
    t_sq_ctx           r2_ctx;

    always_comb begin
        w_b2   = DISC_W'(r1_b2);
        w_p4   = DISC_W'({r1_ac, 2'b00});
        w_dneg = 1'b0;
        if ((r1_ctx.a[COEF_WIDTH-1] != r1_ctx.c[COEF_WIDTH-1]) || (r1_ctx.c == '0)) begin
            w_d = w_b2 + w_p4;
        end else if (w_b2 >= w_p4) begin
            w_d = w_b2 - w_p4;
        end else begin
            w_d    = w_p4 - w_b2;
            w_dneg = 1'b1;
        end
        if (r1_ctx.a == '0 && r1_ctx.b == '0) begin
            w_kind = KIND_NONE;
        end else if (r1_ctx.a == '0) begin
            w_kind = KIND_LINEAR;
        end else if (w_dneg) begin
            w_kind = KIND_COMPLEX;
        end else if (w_d == '0) begin
            w_kind = KIND_ONE_REAL;
        end else begin
            w_kind = KIND_TWO_REAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
        if (w_en) begin
            r2_rad      <= RAD_W'({w_d, {(2 * FRAC_BITS){1'b0}}});
            r2_ctx.a    <= r1_ctx.a;
            r2_ctx.b    <= r1_ctx.b;
            r2_ctx.c    <= r1_ctx.c;
            r2_ctx.kind <= w_kind;
        end
    end

    // square root row
    logic                sq_valid [0:SQ_W];
    logic [RAD_W-1:0]    sq_rad   [0:SQ_W];
    logic [SQ_REM_W-1:0] sq_rem   [0:SQ_W];
    logic [SQ_W-1:0]     sq_root  [0:SQ_W];
    t_sq_ctx             sq_ctx   [0:SQ_W];

    assign sq_valid[0] = r2_valid;
    assign sq_rad[0]   = r2_rad;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_ctx[0]   = r2_ctx;

    for (genvar g = 0; g < SQ_W; g++) begin : g_sq
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (sq_valid[g]),
            .i_rad   (sq_rad[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_ctx   (sq_ctx[g]),
            .o_valid (sq_valid[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_ctx   (sq_ctx[g+1])
        );
    end

    // dividends and divisor
    t_sq_ctx                w_sc;
    logic signed [NUM_W:0]  w_s, w_nb, w_n1, w_n2;
    logic signed [DEN_W:0]  w_den;
    logic                   r3_valid;
    logic [DEN_W-1:0]       r3_den;
    logic [NUM_W-1:0]       r3_num1, r3_num2;
    t_dv_ctx                r3_ctx;

    always_comb begin
        w_sc  = sq_ctx[SQ_W];
        w_s   = (NUM_W + 1)'(sq_root[SQ_W]);
        w_nb  = scale_neg(w_sc.b);
        w_den = {w_sc.a[COEF_WIDTH-1], w_sc.a, 1'b0};
        w_n1  = '0;
        w_n2  = '0;
        case (w_sc.kind)
            KIND_NONE: begin
                w_den = (DEN_W + 1)'(1);
            end
            KIND_LINEAR: begin
                w_n1  = scale_neg(w_sc.c);
                w_den = (DEN_W + 1)'(w_sc.b);
            end
            KIND_TWO_REAL: begin
                w_n1 = w_nb + w_s;
                w_n2 = w_nb - w_s;
            end
            KIND_ONE_REAL: begin
                w_n1 = w_nb;
            end
            KIND_COMPLEX: begin
                w_n1 = w_nb;
                w_n2 = w_s;
            end
            default: begin
                w_den = (DEN_W + 1)'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= sq_valid[SQ_W];
        end
        if (w_en) begin
            r3_den  <= w_den[DEN_W] ? DEN_W'(-w_den) : DEN_W'(w_den);
            r3_num1 <= w_n1[NUM_W] ? NUM_W'(-w_n1) : NUM_W'(w_n1);
            r3_num2 <= w_n2[NUM_W] ? NUM_W'(-w_n2) : NUM_W'(w_n2);
            r3_ctx.kind <= w_sc.kind;
            r3_ctx.neg1 <= w_n1[NUM_W] ^ w_den[DEN_W];
            r3_ctx.neg2 <= w_n2[NUM_W] ^ w_den[DEN_W];
        end
    end

    // divider row
    logic             dv_valid [0:NUM_W];
    logic [DEN_W-1:0] dv_den   [0:NUM_W];
    logic [DEN_W-1:0] dv_rem1  [0:NUM_W];
    logic [DEN_W-1:0] dv_rem2  [0:NUM_W];
    logic [NUM_W-1:0] dv_num1  [0:NUM_W];
    logic [NUM_W-1:0] dv_num2  [0:NUM_W];
    t_dv_ctx          dv_ctx   [0:NUM_W];

    assign dv_valid[0] = r3_valid;
    assign dv_den[0]   = r3_den;
    assign dv_rem1[0]  = '0;
    assign dv_rem2[0]  = '0;
    assign dv_num1[0]  = r3_num1;
    assign dv_num2[0]  = r3_num2;
    assign dv_ctx[0]   = r3_ctx;

    for (genvar g = 0; g < NUM_W; g++) begin : g_dv
        qrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (dv_valid[g]),
            .i_den   (dv_den[g]),
            .i_rem1  (dv_rem1[g]),
            .i_rem2  (dv_rem2[g]),
            .i_num1  (dv_num1[g]),
            .i_num2  (dv_num2[g]),
            .i_ctx   (dv_ctx[g]),
            .o_valid (dv_valid[g+1]),
            .o_den   (dv_den[g+1]),
            .o_rem1  (dv_rem1[g+1]),
            .o_rem2  (dv_rem2[g+1]),
            .o_num1  (dv_num1[g+1]),
            .o_num2  (dv_num2[g+1]),
            .o_ctx   (dv_ctx[g+1])
        );
    end

    // sign, saturation and output register
    logic signed [NUM_W:0] w_q1, w_q2;
    t_dv_ctx               w_dc;
    logic                  r_out_valid;
    logic [2:0]            r_out_kind;
    t_root                 r_out_r1, r_out_r2;

    always_comb begin
        w_dc = dv_ctx[NUM_W];
        w_q1 = (NUM_W + 1)'(dv_num1[NUM_W]);
        w_q2 = (NUM_W + 1)'(dv_num2[NUM_W]);
        if (w_dc.neg1) w_q1 = -w_q1;
        if (w_dc.neg2) w_q2 = -w_q2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= dv_valid[NUM_W];
        end
        if (w_en) begin
            r_out_kind <= w_dc.kind;
            r_out_r1   <= saturate(w_q1);
            r_out_r2   <= saturate(w_q2);
        end
    end

    assign o_root.valid       = r_out_valid;
    assign o_root.root_kind   = r_out_kind;
    assign o_root.first_root  = r_out_r1;
    assign o_root.second_root = r_out_r2;
endmodule

[rtl/qrs_checker.sv]
// port-level checks of the quadratic root solver
module qrs_checker import qrs_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_kind,
    input t_root      i_first,
    input t_root      i_second
);
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == KIND_NONE) |-> (i_first == '0 && i_second == '0))
        else $error("no-equation result with nonzero roots");

    a_single_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind == KIND_LINEAR || i_kind == KIND_ONE_REAL))
            |-> (i_second == '0))
        else $error("single-root result with nonzero second root");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output register is empty");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
            |=> (i_out_valid && $stable(i_kind) && $stable(i_first) && $stable(i_second)))
        else $error("stalled result changed");
endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_coef.ready),
    .i_out_valid (o_root.valid),
    .i_out_ready (o_root.ready),
    .i_kind      (o_root.root_kind),
    .i_first     (o_root.first_root),
    .i_second    (o_root.second_root)
);

[test/quadratic_root_solver_core_tb.sv]
// self-checking testbench for the quadratic root solver core
module quadratic_root_solver_core_tb;
    import qrs_pkg::*;

    typedef struct {
        t_coef a;
        t_coef b;
        t_coef c;
    } t_coefs;

    typedef struct {
        t_kind kind;
        t_root r1;
        t_root r2;
    } t_roots;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 120;
    localparam int CALM_TAIL     = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT_COUNT = 400;

    logic i_clk;
    logic i_rst_n;

    qrs_in_if  coef_ch ();
    qrs_out_if root_ch ();

    quadratic_root_solver_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef_ch.sink),
        .o_root  (root_ch.source)
    );

    t_coefs pending_sets[$];
    t_roots expected_roots[$];
    int     mismatches;
    int     roots_seen;
    int     kind_count[5];
    int     cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_root saturate(longint v);
        longint hi_lim;
        longint lo_lim;
        hi_lim = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
        lo_lim = -hi_lim - 1;
        if (v > hi_lim) return t_root'(hi_lim);
        if (v < lo_lim) return t_root'(lo_lim);
        return t_root'(v);
    endfunction

    // floor square root, two bits per step
    function automatic longint floor_sqrt(logic [127:0] x);
        logic [127:0] rem;
        logic [127:0] root;
        logic [127:0] trial;
        rem  = '0;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            rem   = (rem << 2) | ((x >> (2 * i)) & 128'd3);
            root  = root << 1;
            trial = (root << 1) | 128'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = root | 128'd1;
            end
        end
        return longint'(root[63:0]);
    endfunction

    function automatic t_roots solve_roots(t_coefs s);
        t_roots res;
        longint a;
        longint b;
        longint c;
        longint nb;
        longint disc;
        longint den;
        longint sq;
        logic [127:0] rad;
        a = s.a;
        b = s.b;
        c = s.c;
        nb = -b * (longint'(1) <<< FRAC_BITS);
        res.kind = KIND_NONE;
        res.r1 = '0;
        res.r2 = '0;
        if (a == 0 && b == 0) begin
            res.kind = KIND_NONE;
        end else if (a == 0) begin
            res.kind = KIND_LINEAR;
            res.r1 = saturate((-c * (longint'(1) <<< FRAC_BITS)) / b);
        end else begin
            disc = b * b - 4 * a * c;
            den  = 2 * a;
            rad  = 128'(disc < 0 ? -disc : disc) << (2 * FRAC_BITS);
            sq   = floor_sqrt(rad);
            if (disc < 0) begin
                res.kind = KIND_COMPLEX;
                res.r1 = saturate(nb / den);
                res.r2 = saturate(sq / den);
            end else if (disc == 0) begin
                res.kind = KIND_ONE_REAL;
                res.r1 = saturate(nb / den);
            end else begin
                res.kind = KIND_TWO_REAL;
                res.r1 = saturate((nb + sq) / den);
                res.r2 = saturate((nb - sq) / den);
            end
        end
        return res;
    endfunction

    function automatic t_coefs make_set(int a, int b, int c);
        t_coefs s;
        s.a = t_coef'(a);
        s.b = t_coef'(b);
        s.c = t_coef'(c);
        return s;
    endfunction

    function automatic int rand_coef();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int rand_small(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic t_coefs random_set();
        int pick;
        int a;
        int p;
        int q;
        pick = $urandom_range(0, 15);
        case (pick)
            0: return make_set(0, 0, rand_coef());
            1, 2: return make_set(0, rand_coef(), rand_coef());
            3, 4, 5: begin
                // a*(x-p)*(x-q): real roots with a known discriminant
                a = rand_small(12);
                if (a == 0) a = 1;
                p = rand_small(40);
                q = rand_small(40);
                return make_set(a, -a * (p + q), a * p * q);
            end
            6: begin
                // double root
                a = rand_small(12);
                if (a == 0) a = -1;
                p = rand_small(50);
                return make_set(a, -2 * a * p, a * p * p);
            end
            7: return make_set(rand_small(8), rand_small(8), rand_small(8));
            default: return make_set(rand_coef(), rand_coef(), rand_coef());
        endcase
    endfunction

    // coefficient sender
    int idle_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coef_ch.valid  <= 1'b0;
            coef_ch.coef_a <= '0;
            coef_ch.coef_b <= '0;
            coef_ch.coef_c <= '0;
            idle_left      <= 0;
        end else begin
            if (coef_ch.valid && coef_ch.ready)
                expected_roots.push_back(solve_roots(make_set(coef_ch.coef_a,
                    coef_ch.coef_b, coef_ch.coef_c)));
            if (!coef_ch.valid || coef_ch.ready) begin
                if (idle_left > 0) begin
                    idle_left     <= idle_left - 1;
                    coef_ch.valid <= 1'b0;
                end else if (pending_sets.size() > CALM_TAIL
                             && $urandom_range(0, 7) == 0) begin
                    idle_left     <= $urandom_range(0, 4);
                    coef_ch.valid <= 1'b0;
                end else if (pending_sets.size() > 0) begin
                    t_coefs s;
                    s = pending_sets.pop_front();
                    coef_ch.valid  <= 1'b1;
                    coef_ch.coef_a <= s.a;
                    coef_ch.coef_b <= s.b;
                    coef_ch.coef_c <= s.c;
                end else begin
                    coef_ch.valid <= 1'b0;
                end
            end
        end
    end

    // root receiver and checker
    int stall_left;
    int hold_left;
    bit held_once;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            root_ch.ready <= 1'b0;
            stall_left    <= 0;
            hold_left     <= 0;
            held_once     <= 1'b0;
        end else begin
            if (root_ch.valid && root_ch.ready) begin
                t_roots want;
                roots_seen++;
                if (expected_roots.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: kind %0d roots %0d %0d",
                                 root_ch.root_kind, root_ch.first_root,
                                 root_ch.second_root);
                end else begin
                    want = expected_roots.pop_front();
                    if (want.kind <= KIND_COMPLEX) kind_count[want.kind]++;
                    if (root_ch.root_kind !== want.kind || root_ch.first_root !== want.r1
                        || root_ch.second_root !== want.r2) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected kind %0d roots %0d %0d, got %0d %0d %0d",
                                     want.kind, want.r1, want.r2, root_ch.root_kind,
                                     root_ch.first_root, root_ch.second_root);
                    end
                end
            end
            if (!held_once && roots_seen >= HOLD_AT_COUNT) begin
                // long hold-off so the pipeline fills and backs up
                held_once     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                root_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                root_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left    <= stall_left - 1;
                root_ch.ready <= 1'b0;
            end else if (pending_sets.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                stall_left    <= $urandom_range(0, 4);
                root_ch.ready <= 1'b0;
            end else begin
                root_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        roots_seen = 0;
        cycles     = 0;
        i_rst_n    = 1'b0;
        // directed sets: extremes and every kind
        pending_sets.push_back(make_set(0, 0, 0));
        pending_sets.push_back(make_set(0, 0, -32768));
        pending_sets.push_back(make_set(0, 1, -32768));
        pending_sets.push_back(make_set(0, -1, 32767));
        pending_sets.push_back(make_set(0, -32768, -32768));
        pending_sets.push_back(make_set(0, 3, 7));
        pending_sets.push_back(make_set(1, -3, 2));
        pending_sets.push_back(make_set(-1, 3, -2));
        pending_sets.push_back(make_set(1, -2, 1));
        pending_sets.push_back(make_set(-4, 4, -1));
        pending_sets.push_back(make_set(1, 0, 1));
        pending_sets.push_back(make_set(-1, 2, -5));
        pending_sets.push_back(make_set(1, -32768, -32768));
        pending_sets.push_back(make_set(1, -32768, 32767));
        pending_sets.push_back(make_set(-32768, -32768, -32768));
        pending_sets.push_back(make_set(32767, 32767, 32767));
        pending_sets.push_back(make_set(-32768, 32767, 32767));
        pending_sets.push_back(make_set(32767, -32768, -32768));
        pending_sets.push_back(make_set(1, 1, 0));
        pending_sets.push_back(make_set(-1, 0, 0));
        pending_sets.push_back(make_set(1, 0, -32768));
        pending_sets.push_back(make_set(-32768, 0, 32767));
        for (int i = 0; i < 1230; i++)
            pending_sets.push_back(random_set());
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_sets.size() == 0);
        @(posedge i_clk);
        while (coef_ch.valid || expected_roots.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d root sets: none %0d, linear %0d, two real %0d, one real %0d,",
                 roots_seen, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        $display("complex %0d; %0d mismatches, with one long receiver hold-off",
                 kind_count[4], mismatches);
        if (mismatches == 0 && expected_roots.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/qrs_pkg.sv
rtl/qrs_ifs.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver_core.sv
rtl/qrs_checker.sv
test/quadratic_root_solver_core_tb.sv
